[rtl/lmfb_pkg.sv]
// lmfb_pkg.sv: shared types, constants and the control store of the LED matrix sequencer
`default_nettype none
package lmfb_pkg;

	// matrix size and derived widths
	localparam int COLS  = 16;
	localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;

	// driver command bytes
	localparam logic [7:0] CMD_FIXED_ADDR = 8'h44;
	localparam logic [7:0] CMD_ADDR_BASE  = 8'hC0;
	localparam logic [7:0] CMD_CTRL_BASE  = 8'h88;
	localparam logic [7:0] CTRL_ON_BIT    = 8'h08;

	// reset value of the brightness register
	localparam logic [2:0] BRIGHT_RESET = 3'd7;

	// input function codes
	typedef enum logic [2:0] {
		FN_SET_PIXEL = 3'd0,
		FN_CLEAR     = 3'd1,
		FN_REFRESH   = 3'd2,
		FN_SEGMENT   = 3'd3,
		FN_BLANK     = 3'd4,
		FN_ON_OFF    = 3'd5
	} func_t;

	// control store addresses
	typedef enum logic [3:0] {
		STEP_IDLE = 4'd0,
		STEP_PIX  = 4'd1,
		STEP_CLR  = 4'd2,
		STEP_SEG0 = 4'd3,
		STEP_SEG1 = 4'd4,
		STEP_SEG2 = 4'd5,
		STEP_SEG3 = 4'd6,
		STEP_ON0  = 4'd7,
		STEP_ON1  = 4'd8
	} step_t;

	// source of the emitted byte
	typedef enum logic [2:0] {
		BS_CMD,
		BS_ADDR,
		BS_DATA,
		BS_CTRL,
		BS_ONOFF
	} bsel_t;

	// sequencing of the step counter
	typedef enum logic [1:0] {
		SQ_DISPATCH,
		SQ_GOTO,
		SQ_LOOP
	} seq_t;

	// frame store action
	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_PIX,
		ACT_CLR
	} act_t;

	// one control word
	typedef struct packed {
		logic  emit;
		bsel_t bsel;
		logic  st;
		logic  en;
		logic  lst;
		seq_t  seq;
		act_t  act;
		step_t nxt;
	} uword_t;

	// the microprogram
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w = '{emit: 1'b0, bsel: BS_CMD, st: 1'b0, en: 1'b0, lst: 1'b0,
		      seq: SQ_GOTO, act: ACT_NONE, nxt: STEP_IDLE};
		unique case (s)
			STEP_IDLE: begin
				w.seq = SQ_DISPATCH;
			end
			STEP_PIX: begin
				w.act = ACT_PIX;
			end
			STEP_CLR: begin
				w.act = ACT_CLR;
			end
			STEP_SEG0: begin
				w.emit = 1'b1; w.bsel = BS_CMD; w.st = 1'b1; w.en = 1'b1;
				w.nxt = STEP_SEG1;
			end
			STEP_SEG1: begin
				w.emit = 1'b1; w.bsel = BS_ADDR; w.st = 1'b1;
				w.nxt = STEP_SEG2;
			end
			STEP_SEG2: begin
				w.emit = 1'b1; w.bsel = BS_DATA; w.en = 1'b1;
				w.nxt = STEP_SEG3;
			end
			STEP_SEG3: begin
				w.emit = 1'b1; w.bsel = BS_CTRL; w.st = 1'b1; w.en = 1'b1;
				w.seq = SQ_LOOP; w.nxt = STEP_SEG0;
			end
			STEP_ON0: begin
				w.emit = 1'b1; w.bsel = BS_CMD; w.st = 1'b1; w.en = 1'b1;
				w.nxt = STEP_ON1;
			end
			STEP_ON1: begin
				w.emit = 1'b1; w.bsel = BS_ONOFF; w.st = 1'b1; w.en = 1'b1;
				w.lst = 1'b1;
			end
			default: begin
				w.seq = SQ_GOTO;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

[rtl/led_matrix_framebuffer_controller_core.sv]
// led_matrix_framebuffer_controller_core.sv: frame store and driver command sequencer
`default_nettype none
// Keeps one byte per matrix column and turns each input word into the command words
// for a two-wire LED matrix driver, each marked with start and stop frame flags; no
// bit timing is generated here. A microcoded step counter walks a small control store
// and emits at most one byte per cycle into an output register, so the sequencer keeps
// running while the last byte waits to be taken. One input word is taken at a time:
// set pixel and clear store are accepted, then executed; on/off emits two bytes, a segment
// write four, refresh and blank four per column; a stalled output holds the sequencer.
// Func codes 6 and 7 are taken and dropped. The brightness register resets to 7.
module led_matrix_framebuffer_controller_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        func,
	input  wire logic signed [7:0] column,
	input  wire logic signed [7:0] row,
	input  wire logic              pixel_on,
	input  wire logic [3:0]        segment,
	input  wire logic [7:0]        segment_data,
	input  wire logic              display_on,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             bus_byte,
	output logic                   starts_frame,
	output logic                   ends_frame,
	output logic                   last
);

	localparam logic [lmfb_pkg::COL_W-1:0] CMAX = lmfb_pkg::COL_W'(lmfb_pkg::COLS - 1);

	lmfb_pkg::step_t  step_q, step_d;
	lmfb_pkg::uword_t uw;
	logic [lmfb_pkg::COL_W-1:0] cnt_q;
	logic [2:0] func_q;
	logic [7:0] col_q, row_q, segd_q;
	logic [3:0] seg_q;
	logic       pix_q, don_q;
	logic [2:0] bright_q;
	logic [7:0] store_q [lmfb_pkg::COLS];
	logic       out_valid_q, starts_q, ends_q, last_q;
	logic [7:0] byte_q;

	logic       accept, stall, load, more, last_d;
	logic [lmfb_pkg::COL_W-1:0] rd_idx;
	logic [7:0] rd_data, ctrl, byte_d, mask;
	logic [3:0] addr;
	logic       pix_ok;

	// control word of the current step
	assign uw       = lmfb_pkg::ucode(step_q);
	assign in_ready = (step_q == lmfb_pkg::STEP_IDLE);
	assign accept   = in_valid && in_ready;
	assign stall    = uw.emit && out_valid_q && !out_ready;
	assign load     = uw.emit && !stall;
	assign more     = (func_q != lmfb_pkg::FN_SEGMENT) && (cnt_q != CMAX);
	assign last_d   = uw.lst || ((uw.seq == lmfb_pkg::SQ_LOOP) && !more);

	// single read port of the frame store
	assign rd_idx  = (step_q == lmfb_pkg::STEP_PIX) ? col_q[lmfb_pkg::COL_W-1:0] : cnt_q;
	assign rd_data = store_q[rd_idx];
	assign mask    = 8'h80 >> row_q[2:0];
	assign pix_ok  = (row_q[7:3] == 5'd0) && (col_q < 8'(lmfb_pkg::COLS));

	// byte selection
	assign ctrl = lmfb_pkg::CMD_CTRL_BASE + {5'd0, bright_q};
	always_comb begin
		priority if (func_q == lmfb_pkg::FN_REFRESH) begin
			addr = 4'(CMAX - cnt_q);
		end else if (func_q == lmfb_pkg::FN_BLANK) begin
			addr = 4'(cnt_q);
		end else begin
			addr = seg_q;
		end
		unique case (uw.bsel)
			lmfb_pkg::BS_CMD:  byte_d = lmfb_pkg::CMD_FIXED_ADDR;
			lmfb_pkg::BS_ADDR: byte_d = lmfb_pkg::CMD_ADDR_BASE | {4'd0, addr};
			lmfb_pkg::BS_DATA: begin
				priority if (func_q == lmfb_pkg::FN_REFRESH) byte_d = rd_data;
				else if (func_q == lmfb_pkg::FN_BLANK) byte_d = 8'd0;
				else byte_d = segd_q;
			end
			lmfb_pkg::BS_CTRL: byte_d = ctrl;
			lmfb_pkg::BS_ONOFF: byte_d = don_q ? (ctrl | lmfb_pkg::CTRL_ON_BIT)
			                                   : (ctrl & ~lmfb_pkg::CTRL_ON_BIT);
			default: byte_d = ctrl;
		endcase
	end

	// next step
	always_comb begin
		step_d = step_q;
		unique case (uw.seq)
			lmfb_pkg::SQ_DISPATCH: begin
				if (accept) begin
					unique case (func)
						lmfb_pkg::FN_SET_PIXEL: step_d = lmfb_pkg::STEP_PIX;
						lmfb_pkg::FN_CLEAR:     step_d = lmfb_pkg::STEP_CLR;
						lmfb_pkg::FN_REFRESH,
						lmfb_pkg::FN_SEGMENT,
						lmfb_pkg::FN_BLANK:     step_d = lmfb_pkg::STEP_SEG0;
						lmfb_pkg::FN_ON_OFF:    step_d = lmfb_pkg::STEP_ON0;
						default:                step_d = lmfb_pkg::STEP_IDLE;
					endcase
				end
			end
			lmfb_pkg::SQ_GOTO: begin
				if (!stall) step_d = uw.nxt;
			end
			lmfb_pkg::SQ_LOOP: begin
				if (!stall) step_d = more ? uw.nxt : lmfb_pkg::STEP_IDLE;
			end
			default: step_d = lmfb_pkg::STEP_IDLE;
		endcase
	end

	// sequencer, counter and brightness
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= lmfb_pkg::STEP_IDLE;
			cnt_q    <= '0;
			bright_q <= lmfb_pkg::BRIGHT_RESET;
		end else begin
			step_q <= step_d;
			if (cfg_we) bright_q <= cfg_data;
			if (accept) begin
				cnt_q <= '0;
			end else if ((uw.seq == lmfb_pkg::SQ_LOOP) && !stall && more) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// latched input word
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			col_q  <= column;
			row_q  <= row;
			pix_q  <= pixel_on;
			seg_q  <= segment;
			segd_q <= segment_data;
			don_q  <= display_on;
		end
	end

	// frame store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lmfb_pkg::COLS; i++) store_q[i] <= 8'd0;
		end else begin
			if (uw.act == lmfb_pkg::ACT_CLR) begin
				for (int i = 0; i < lmfb_pkg::COLS; i++) store_q[i] <= 8'd0;
			end else if ((uw.act == lmfb_pkg::ACT_PIX) && pix_ok) begin
				store_q[rd_idx] <= pix_q ? (rd_data | mask) : (rd_data & ~mask);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= byte_d;
			starts_q <= uw.st;
			ends_q   <= uw.en;
			last_q   <= last_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign bus_byte     = byte_q;
	assign starts_frame = starts_q;
	assign ends_frame   = ends_q;
	assign last         = last_q;

	// the final word of an item returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_d) |=> (step_q == lmfb_pkg::STEP_IDLE))
		else $error("sequencer not idle after final word");

	// a column walk starts at the first column
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ((func == lmfb_pkg::FN_REFRESH) || (func == lmfb_pkg::FN_BLANK)))
		|=> ((step_q == lmfb_pkg::STEP_SEG0) && (cnt_q == '0)))
		else $error("column walk did not start at column zero");

	// the column counter steps by one per segment write
	a_walk_step: assert property (@(posedge clk) disable iff (!arst_n)
		((uw.seq == lmfb_pkg::SQ_LOOP) && !stall && more && !accept)
		|=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("column counter did not advance");

	// no new input word while a stalled byte waits to be registered
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stall |-> !in_ready)
		else $error("input taken while output stalled");

endmodule
`default_nettype wire

[bench/lmfb_command_checker.sv]
`timescale 1ns / 100ps
// lmfb_command_checker.sv: watches the sequencer channels, predicts its bytes and compares
module lmfb_command_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [2:0] func,
	input  logic [7:0] column,
	input  logic [7:0] row,
	input  logic       pixel_on,
	input  logic [3:0] segment,
	input  logic [7:0] segment_data,
	input  logic       display_on,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] bus_byte,
	input  logic       starts_frame,
	input  logic       ends_frame,
	input  logic       last,
	output int         errors,
	output int         pending,
	output int         words_seen,
	output int         bytes_checked
);

	localparam int         NUM_COLS   = 16;
	localparam logic [7:0] FIXED_ADDR = 8'h44;
	localparam logic [7:0] ADDR_CMD   = 8'hC0;
	localparam logic [7:0] CTRL_CMD   = 8'h88;
	localparam logic [7:0] DISPLAY_ON = 8'h08;

	// one byte on the driver bus with its frame marks
	typedef struct packed {
		logic [7:0] value;
		logic       st;
		logic       en;
		logic       lst;
	} drv_byte_t;

	// shadow copy of the frame store and brightness
	logic [7:0] shadow_cols [NUM_COLS];
	logic [2:0] bright = 3'd7;
	drv_byte_t  bytes_due [$];
	drv_byte_t  word_bytes [$];

	function automatic logic [7:0] ctrl_byte();
		return CTRL_CMD + {5'd0, bright};
	endfunction

	task automatic stage(input logic [7:0] value, input logic st, input logic en);
		word_bytes.push_back('{value: value, st: st, en: en, lst: 1'b0});
	endtask

	// fixed-address command, address with data, then the control byte
	task automatic stage_segment(input logic [3:0] addr, input logic [7:0] data);
		stage(FIXED_ADDR, 1'b1, 1'b1);
		stage(ADDR_CMD | {4'd0, addr}, 1'b1, 1'b0);
		stage(data, 1'b0, 1'b1);
		stage(ctrl_byte(), 1'b1, 1'b1);
	endtask

	// work out the bus bytes one command word causes
	task automatic predict_commands(input logic [2:0] fn, input logic [7:0] col,
			input logic [7:0] rw, input logic pix, input logic [3:0] seg,
			input logic [7:0] data, input logic on);
		int d;
		logic [7:0] mask;
		word_bytes.delete();
		case (fn)
			lmfb_pkg::FN_SET_PIXEL: begin
				// negative column or row reads as large unsigned and is dropped
				if (col < NUM_COLS && rw < 8) begin
					mask = 8'h80 >> rw[2:0];
					if (pix)
						shadow_cols[col[3:0]] |= mask;
					else
						shadow_cols[col[3:0]] &= ~mask;
				end
			end
			lmfb_pkg::FN_CLEAR: begin
				foreach (shadow_cols[i])
					shadow_cols[i] = 8'h00;
			end
			lmfb_pkg::FN_REFRESH: begin
				// column d goes out to the mirrored address
				for (d = 0; d < NUM_COLS; d++)
					stage_segment(4'(NUM_COLS - 1 - d), shadow_cols[d]);
			end
			lmfb_pkg::FN_SEGMENT: begin
				stage_segment(seg, data);
			end
			lmfb_pkg::FN_BLANK: begin
				for (d = 0; d < NUM_COLS; d++)
					stage_segment(4'(d), 8'h00);
			end
			lmfb_pkg::FN_ON_OFF: begin
				stage(FIXED_ADDR, 1'b1, 1'b1);
				if (on)
					stage(ctrl_byte() | DISPLAY_ON, 1'b1, 1'b1);
				else
					stage(ctrl_byte() & ~DISPLAY_ON, 1'b1, 1'b1);
			end
			default: begin
			end
		endcase
		if (word_bytes.size() > 0)
			word_bytes[word_bytes.size() - 1].lst = 1'b1;
		foreach (word_bytes[i])
			bytes_due.push_back(word_bytes[i]);
	endtask

	// compare one accepted bus byte with the oldest one due
	task automatic check_byte();
		drv_byte_t want;
		if (bytes_due.size() == 0) begin
			$error("bus_byte %h arrived with nothing due", bus_byte);
			errors++;
		end else begin
			want = bytes_due.pop_front();
			bytes_checked++;
			if (bus_byte !== want.value) begin
				$error("bus_byte: expected %h, got %h", want.value, bus_byte);
				errors++;
			end
			if (starts_frame !== want.st) begin
				$error("starts_frame: expected %b, got %b", want.st, starts_frame);
				errors++;
			end
			if (ends_frame !== want.en) begin
				$error("ends_frame: expected %b, got %b", want.en, ends_frame);
				errors++;
			end
			if (last !== want.lst) begin
				$error("last: expected %b, got %b", want.lst, last);
				errors++;
			end
		end
	endtask

	// sample both channels and the register port at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (shadow_cols[i])
				shadow_cols[i] = 8'h00;
			bright = 3'd7;
			bytes_due.delete();
			pending = 0;
		end else begin
			if (cfg_we)
				bright = cfg_data;
			if (out_valid && out_ready)
				check_byte();
			if (in_valid && in_ready) begin
				predict_commands(func, column, row, pixel_on, segment, segment_data,
					display_on);
				words_seen++;
			end
			pending = bytes_due.size();
		end
	end

endmodule

[bench/led_matrix_framebuffer_controller_core_test.sv]
`timescale 1ns / 100ps
// led_matrix_framebuffer_controller_core_test.sv: stimulus and verdict for the LED matrix sequencer
module led_matrix_framebuffer_controller_core_test;

	localparam logic [2:0] FN_SPARE_A  = 3'd6;
	localparam logic [2:0] FN_SPARE_B  = 3'd7;
	localparam int         PHASES      = 5;
	localparam int         PHASE_WORDS = 88;
	localparam int         GAP_MAX     = 18;
	localparam int         LONG_HOLD   = 400;
	localparam int         SETTLE      = 10;
	localparam int         DRAIN       = 70;

	// one command word as driven on the input channel
	typedef struct packed {
		logic [2:0] fn;
		logic [7:0] col;
		logic [7:0] rw;
		logic       pix;
		logic [3:0] seg;
		logic [7:0] seg_data;
		logic       on;
	} matrix_cmd_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [2:0]        cfg_data = 3'd0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [2:0]        func = 3'd0;
	logic signed [7:0] column = 8'sd0;
	logic signed [7:0] row = 8'sd0;
	logic              pixel_on = 1'b0;
	logic [3:0]        segment = 4'd0;
	logic [7:0]        segment_data = 8'd0;
	logic              display_on = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        bus_byte;
	logic              starts_frame;
	logic              ends_frame;
	logic              last;

	int errors;
	int pending;
	int words_seen;
	int bytes_checked;
	int settings_done = 0;
	bit sender_burst = 1'b0;
	bit receiver_burst = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	led_matrix_framebuffer_controller_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.column       (column),
		.row          (row),
		.pixel_on     (pixel_on),
		.segment      (segment),
		.segment_data (segment_data),
		.display_on   (display_on),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.bus_byte     (bus_byte),
		.starts_frame (starts_frame),
		.ends_frame   (ends_frame),
		.last         (last)
	);

	lmfb_command_checker scoreboard (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.column        (column),
		.row           (row),
		.pixel_on      (pixel_on),
		.segment       (segment),
		.segment_data  (segment_data),
		.display_on    (display_on),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.bus_byte      (bus_byte),
		.starts_frame  (starts_frame),
		.ends_frame    (ends_frame),
		.last          (last),
		.errors        (errors),
		.pending       (pending),
		.words_seen    (words_seen),
		.bytes_checked (bytes_checked)
	);

	// command word with every field random apart from the function
	function automatic matrix_cmd_t any_cmd(input logic [2:0] fn);
		matrix_cmd_t c;
		c.fn = fn;
		c.col = 8'($urandom);
		c.rw = 8'($urandom);
		c.pix = 1'($urandom);
		c.seg = 4'($urandom);
		c.seg_data = 8'($urandom);
		c.on = 1'($urandom);
		return c;
	endfunction

	function automatic matrix_cmd_t pixel_cmd(input logic [7:0] col, input logic [7:0] rw,
			input logic pix);
		matrix_cmd_t c;
		c = any_cmd(lmfb_pkg::FN_SET_PIXEL);
		c.col = col;
		c.rw = rw;
		c.pix = pix;
		return c;
	endfunction

	// random mix, pixel edits mostly on the matrix
	function automatic matrix_cmd_t random_cmd();
		int pick;
		matrix_cmd_t c;
		pick = $urandom_range(0, 99);
		if (pick < 44) begin
			c = any_cmd(lmfb_pkg::FN_SET_PIXEL);
			if ($urandom_range(0, 7) != 0) begin
				c.col = 8'($urandom_range(0, 15));
				c.rw = 8'($urandom_range(0, 7));
			end
		end else if (pick < 50)
			c = any_cmd(lmfb_pkg::FN_CLEAR);
		else if (pick < 63)
			c = any_cmd(lmfb_pkg::FN_REFRESH);
		else if (pick < 77)
			c = any_cmd(lmfb_pkg::FN_SEGMENT);
		else if (pick < 83)
			c = any_cmd(lmfb_pkg::FN_BLANK);
		else if (pick < 94)
			c = any_cmd(lmfb_pkg::FN_ON_OFF);
		else if (pick < 97)
			c = any_cmd(FN_SPARE_A);
		else
			c = any_cmd(FN_SPARE_B);
		return c;
	endfunction

	// offer one word after a random gap and hold it until taken
	task automatic send(input matrix_cmd_t c);
		int gap;
		if ($urandom_range(0, 29) == 0)
			sender_burst = !sender_burst;
		gap = sender_burst ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= c.fn;
		column <= c.col;
		row <= c.rw;
		pixel_on <= c.pix;
		segment <= c.seg;
		segment_data <= c.seg_data;
		display_on <= c.on;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid, let every due byte arrive, then let the sequencer settle
	task automatic wait_idle(input int settle);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_brightness(input logic [2:0] level);
		cfg_we <= 1'b1;
		cfg_data <= level;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_done++;
	endtask

	// receiver: random stalls, plus two long hold-offs so the input backs up
	initial begin
		int taken;
		int hold;
		taken = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				receiver_burst = !receiver_burst;
			if (taken == 300 || taken == 2500)
				hold = LONG_HOLD;
			else
				hold = receiver_burst ? 0 : $urandom_range(0, GAP_MAX);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// stimulus
	initial begin
		matrix_cmd_t c;
		int ph;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store at reset brightness, then display on and off
		send(any_cmd(lmfb_pkg::FN_REFRESH));
		c = any_cmd(lmfb_pkg::FN_ON_OFF);
		c.on = 1'b1;
		send(c);
		c.on = 1'b0;
		send(c);

		// matrix corners, then pixels off the matrix, then one corner cleared and a refresh
		send(pixel_cmd(8'd0, 8'd0, 1'b1));
		send(pixel_cmd(8'd15, 8'd7, 1'b1));
		send(pixel_cmd(8'd15, 8'd0, 1'b1));
		send(pixel_cmd(8'd0, 8'd7, 1'b1));
		send(pixel_cmd(8'd16, 8'd0, 1'b1));
		send(pixel_cmd(8'hFF, 8'd0, 1'b1));
		send(pixel_cmd(8'd0, 8'd8, 1'b1));
		send(pixel_cmd(8'd0, 8'h80, 1'b1));
		send(pixel_cmd(8'h7F, 8'h7F, 1'b1));
		send(pixel_cmd(8'h80, 8'hFF, 1'b1));
		send(pixel_cmd(8'd0, 8'd0, 1'b0));
		send(any_cmd(lmfb_pkg::FN_REFRESH));

		// direct segment writes at both ends of address and data
		c = any_cmd(lmfb_pkg::FN_SEGMENT);
		c.seg = 4'd0;
		c.seg_data = 8'h00;
		send(c);
		c.seg = 4'd15;
		c.seg_data = 8'hFF;
		send(c);

		send(any_cmd(lmfb_pkg::FN_BLANK));
		send(any_cmd(FN_SPARE_A));
		send(any_cmd(FN_SPARE_B));
		send(any_cmd(lmfb_pkg::FN_CLEAR));
		send(any_cmd(lmfb_pkg::FN_REFRESH));

		// random phases, each at its own brightness
		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle(SETTLE);
			case (ph)
				0: set_brightness(3'd0);
				1: set_brightness(3'd7);
				2: set_brightness(3'd3);
				default: set_brightness(3'($urandom));
			endcase
			repeat (PHASE_WORDS) send(random_cmd());
		end

		wait_idle(DRAIN);
		$display("%0d command words over %0d brightness settings, incl. off-matrix pixels",
			words_seen, settings_done + 1);
		$display("%0d driver bytes compared, %0d mismatches", bytes_checked, errors);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#(50_000_000);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
